// ===== src/hcbd_pkg.sv =====
// Shared types, constants and helper functions of the chunked body decoder.
package hcbd_pkg;

  localparam int unsigned DEFAULT_MAX_OUTPUT_BYTES = 1048576;
  localparam int unsigned DEFAULT_SIZE_BITS        = 32;

  localparam int unsigned CAP_W     = 21;
  localparam int unsigned CAP_RESET = 524288;

  localparam logic [7:0] ASCII_CR   = 8'h0D;
  localparam logic [7:0] ASCII_LF   = 8'h0A;
  localparam logic [7:0] ASCII_SEMI = 8'h3B;

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_END     = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_EXT     = 3'd1,
    PH_SIZE_LF = 3'd2,
    PH_DATA    = 3'd3,
    PH_DATA_CR = 3'd4,
    PH_DATA_LF = 3'd5,
    PH_DONE    = 3'd6,
    PH_ERROR   = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_BAD_HEX       = 3'd0,
    ERR_MISSING_SIZE  = 3'd1,
    ERR_BAD_SIZE_CRLF = 3'd2,
    ERR_BAD_DATA_CRLF = 3'd3,
    ERR_EARLY_END     = 3'd4,
    ERR_FULL          = 3'd5,
    ERR_OVERFLOW      = 3'd6
  } err_e;

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
           (b >= 8'h41 && b <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] v;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = b - 8'h30;
    end else if (b >= 8'h61 && b <= 8'h66) begin
      v = b - 8'h57;
    end else begin
      v = b - 8'h37;
    end
    return v[3:0];
  endfunction

endpackage

// ===== src/http_chunked_body_decoder.sv =====
// Top level of the HTTP chunked transfer body decoder.
//
// The decoder takes an encoded chunked body, one item per cycle when not stalled,
// on the slave stream: tuser carries the operation (byte, end of input, restart) and
// tdata the encoded byte. Decoded data bytes, the completion marker and
// error reports leave on the master stream, at most one result per item;
// tuser carries the result kind, tdata the data byte and the error code.
// An accepted item is held in an input register and is decoded from there
// into a result register, from which its result is offered on the master stream.
// One item per cycle is sustained while the receiver takes results, set by the single
// decode step that updates the chunk state and the result register.
// When the receiver stalls with a result pending, the input register fills
// and s_axis_tready_o drops until the result is taken; nothing is lost.
// The output capacity register is written on the cfg channel; its value
// is loaded into the output budget at reset and on every restart.
// Reset clears both stages and starts a new body with the reset capacity.
module http_chunked_body_decoder #(
  parameter int unsigned MAX_OUTPUT_BYTES = hcbd_pkg::DEFAULT_MAX_OUTPUT_BYTES,
  parameter int unsigned SIZE_BITS        = hcbd_pkg::DEFAULT_SIZE_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [7:0]                 s_axis_tdata_i,  // in_byte
  input  logic [1:0]                 s_axis_tuser_i,  // op
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [15:0]                m_axis_tdata_o,  // out_byte, error_code, zero fill
  output logic [1:0]                 m_axis_tuser_o,  // kind
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [hcbd_pkg::CAP_W-1:0] cfg_data_i      // output_capacity
);

  localparam int unsigned RW   = $clog2(MAX_OUTPUT_BYTES + 1);
  localparam int unsigned CMPW = (RW > hcbd_pkg::CAP_W) ? RW : hcbd_pkg::CAP_W;
  localparam logic [RW-1:0] ROOM_RESET = (hcbd_pkg::CAP_RESET > MAX_OUTPUT_BYTES) ?
                                         RW'(MAX_OUTPUT_BYTES) : RW'(hcbd_pkg::CAP_RESET);

  logic [hcbd_pkg::CAP_W-1:0] cap_q;
  logic [RW-1:0]              cap_clamped;

  logic       in_valid_q;
  logic [1:0] in_op_q;
  logic [7:0] in_byte_q;

  hcbd_pkg::phase_e      phase_q, phase_d;
  logic [SIZE_BITS-1:0]  chunk_q, chunk_d;
  logic                  saw_q, saw_d;
  logic [RW-1:0]         room_q, room_d;

  logic            res_valid;
  hcbd_pkg::kind_e res_kind;
  hcbd_pkg::err_e  res_code;
  logic [7:0]      res_byte;

  logic            out_valid_q;
  hcbd_pkg::kind_e out_kind_q;
  hcbd_pkg::err_e  out_code_q;
  logic [7:0]      out_byte_q;

  logic advance;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign cfg_ready_o     = 1'b1;

  assign cap_clamped = (CMPW'(cap_q) > CMPW'(MAX_OUTPUT_BYTES)) ?
                       RW'(MAX_OUTPUT_BYTES) : RW'(cap_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= hcbd_pkg::CAP_W'(hcbd_pkg::CAP_RESET);
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_op_q   <= s_axis_tuser_i;
      in_byte_q <= s_axis_tdata_i;
    end
  end

  // Result of the held item, given the current chunk state.
  always_comb begin
    res_valid = 1'b0;
    res_kind  = hcbd_pkg::KIND_DATA;
    res_code  = hcbd_pkg::ERR_BAD_HEX;
    res_byte  = 8'h00;
    if (in_op_q == hcbd_pkg::OP_BYTE || in_op_q == hcbd_pkg::OP_END) begin
      if (phase_q != hcbd_pkg::PH_DONE && phase_q != hcbd_pkg::PH_ERROR) begin
        if (in_op_q == hcbd_pkg::OP_END || in_byte_q == 8'h00) begin
          res_valid = 1'b1;
          res_kind  = hcbd_pkg::KIND_ERROR;
          res_code  = hcbd_pkg::ERR_EARLY_END;
        end else begin
          case (phase_q)
            hcbd_pkg::PH_SIZE: begin
              if (in_byte_q == hcbd_pkg::ASCII_CR || in_byte_q == hcbd_pkg::ASCII_SEMI) begin
                if (!saw_q) begin
                  res_valid = 1'b1;
                  res_kind  = hcbd_pkg::KIND_ERROR;
                  res_code  = hcbd_pkg::ERR_MISSING_SIZE;
                end
              end else if (!hcbd_pkg::is_hex(in_byte_q)) begin
                res_valid = 1'b1;
                res_kind  = hcbd_pkg::KIND_ERROR;
                res_code  = hcbd_pkg::ERR_BAD_HEX;
              end else if (chunk_q[SIZE_BITS-1 -: 4] != 4'h0) begin
                res_valid = 1'b1;
                res_kind  = hcbd_pkg::KIND_ERROR;
                res_code  = hcbd_pkg::ERR_OVERFLOW;
              end
            end
            hcbd_pkg::PH_SIZE_LF: begin
              if (in_byte_q != hcbd_pkg::ASCII_LF) begin
                res_valid = 1'b1;
                res_kind  = hcbd_pkg::KIND_ERROR;
                res_code  = hcbd_pkg::ERR_BAD_SIZE_CRLF;
              end else if (chunk_q == '0) begin
                res_valid = 1'b1;
                res_kind  = hcbd_pkg::KIND_DONE;
              end
            end
            hcbd_pkg::PH_DATA: begin
              res_valid = 1'b1;
              if (room_q <= RW'(1)) begin
                res_kind = hcbd_pkg::KIND_ERROR;
                res_code = hcbd_pkg::ERR_FULL;
              end else begin
                res_byte = in_byte_q;
              end
            end
            hcbd_pkg::PH_DATA_CR: begin
              if (in_byte_q != hcbd_pkg::ASCII_CR) begin
                res_valid = 1'b1;
                res_kind  = hcbd_pkg::KIND_ERROR;
                res_code  = hcbd_pkg::ERR_BAD_DATA_CRLF;
              end
            end
            hcbd_pkg::PH_DATA_LF: begin
              if (in_byte_q != hcbd_pkg::ASCII_LF) begin
                res_valid = 1'b1;
                res_kind  = hcbd_pkg::KIND_ERROR;
                res_code  = hcbd_pkg::ERR_BAD_DATA_CRLF;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  // Next chunk state for the held item.
  always_comb begin
    phase_d = phase_q;
    chunk_d = chunk_q;
    saw_d   = saw_q;
    room_d  = room_q;
    if (in_op_q == hcbd_pkg::OP_RESTART) begin
      phase_d = hcbd_pkg::PH_SIZE;
      chunk_d = '0;
      saw_d   = 1'b0;
      room_d  = cap_clamped;
    end else if (res_valid && res_kind == hcbd_pkg::KIND_ERROR) begin
      phase_d = hcbd_pkg::PH_ERROR;
    end else if (in_op_q == hcbd_pkg::OP_BYTE && in_byte_q != 8'h00) begin
      case (phase_q)
        hcbd_pkg::PH_SIZE: begin
          if (in_byte_q == hcbd_pkg::ASCII_CR) begin
            phase_d = hcbd_pkg::PH_SIZE_LF;
          end else if (in_byte_q == hcbd_pkg::ASCII_SEMI) begin
            phase_d = hcbd_pkg::PH_EXT;
          end else begin
            chunk_d = {chunk_q[SIZE_BITS-5:0], hcbd_pkg::hex_val(in_byte_q)};
            saw_d   = 1'b1;
          end
        end
        hcbd_pkg::PH_EXT: begin
          if (in_byte_q == hcbd_pkg::ASCII_CR) begin
            phase_d = hcbd_pkg::PH_SIZE_LF;
          end
        end
        hcbd_pkg::PH_SIZE_LF: begin
          phase_d = (chunk_q == '0) ? hcbd_pkg::PH_DONE : hcbd_pkg::PH_DATA;
        end
        hcbd_pkg::PH_DATA: begin
          room_d  = room_q - RW'(1);
          chunk_d = chunk_q - SIZE_BITS'(1);
          if (chunk_q == SIZE_BITS'(1)) begin
            phase_d = hcbd_pkg::PH_DATA_CR;
          end
        end
        hcbd_pkg::PH_DATA_CR: begin
          phase_d = hcbd_pkg::PH_DATA_LF;
        end
        hcbd_pkg::PH_DATA_LF: begin
          phase_d = hcbd_pkg::PH_SIZE;
          chunk_d = '0;
          saw_d   = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hcbd_pkg::PH_SIZE;
      chunk_q <= '0;
      saw_q   <= 1'b0;
      room_q  <= ROOM_RESET;
    end else if (advance) begin
      phase_q <= phase_d;
      chunk_q <= chunk_d;
      saw_q   <= saw_d;
      room_q  <= room_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_kind_q <= res_kind;
      out_code_q <= res_code;
      out_byte_q <= res_byte;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tdata_o  = {5'b0, out_code_q, out_byte_q};

`ifndef NO_ASSERTIONS
  a_done_from_size_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_valid && res_kind == hcbd_pkg::KIND_DONE) |->
      phase_q == hcbd_pkg::PH_SIZE_LF)
    else $error("completion reported outside the size line end");

  a_error_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_valid && res_kind == hcbd_pkg::KIND_ERROR) |=>
      phase_q == hcbd_pkg::PH_ERROR)
    else $error("error result did not move the decoder to the error phase");

  a_data_spends_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_valid && res_kind == hcbd_pkg::KIND_DATA) |=>
      room_q == $past(room_q) - RW'(1))
    else $error("data item did not spend one byte of output room");

  a_room_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMPW'(room_q) <= CMPW'(MAX_OUTPUT_BYTES))
    else $error("output room above the maximum");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input taken while both stages are held");
`endif

endmodule

// ===== bench/http_chunked_body_decoder_test.sv =====
// Self-checking testbench of the HTTP chunked body decoder with its own decode predictor.
`timescale 1ns / 100ps

module http_chunked_body_decoder_test;

  localparam logic [1:0] OP_UNUSED     = 2'd3;
  localparam logic [2:0] NO_CODE       = 3'd0;
  localparam int         SZ            = hcbd_pkg::DEFAULT_SIZE_BITS;
  localparam int         SETTLE_CYCLES = 6;
  localparam int         HOLD_CYCLES   = 400;
  localparam int         SEG_ITEMS     = 72;
  localparam int         CYCLE_LIMIT   = 300000;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [2:0] code;
  } result_t;

  typedef struct {
    logic [1:0] op;
    logic [7:0] data;
    int         reps;
    bit         fixed;
    bit         has;
    result_t    res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic s_valid;
  logic [7:0] s_data;
  logic [1:0] s_user;
  logic m_ready = 1'b0;
  logic cfg_valid;
  logic [hcbd_pkg::CAP_W-1:0] cfg_data;
  logic s_axis_tready_o;
  logic m_axis_tvalid_o;
  logic [15:0] m_axis_tdata_o;
  logic [1:0] m_axis_tuser_o;
  logic cfg_ready_o;

  // Predictor state of the decoder.
  hcbd_pkg::phase_e dec_phase;
  logic [SZ-1:0] chunk_left;
  bit digit_seen;
  int unsigned room_left;
  logic [hcbd_pkg::CAP_W-1:0] capacity_reg;

  result_t decoder_out_q[$];
  stim_row_t plan_q[$];
  logic [9:0] body_q[$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_requests;
  int hold_served = 0;
  int hold_left = 0;
  int fed_items;
  int mismatches;
  int cycle_count = 0;
  int unsigned seg_cap[5] = '{20, 0, 2097151, 1, 1048576};

  http_chunked_body_decoder DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when the stimulus asks for one.
  always @(posedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic result_t mk_result(logic [1:0] kind, logic [7:0] data, logic [2:0] code);
    return {kind, data, code};
  endfunction

  function automatic void start_body();
    dec_phase = hcbd_pkg::PH_SIZE;
    chunk_left = '0;
    digit_seen = 1'b0;
    room_left = (capacity_reg > hcbd_pkg::DEFAULT_MAX_OUTPUT_BYTES) ?
                hcbd_pkg::DEFAULT_MAX_OUTPUT_BYTES : capacity_reg;
  endfunction

  function automatic result_t fail_with(hcbd_pkg::err_e code);
    dec_phase = hcbd_pkg::PH_ERROR;
    return mk_result(hcbd_pkg::KIND_ERROR, 8'h00, code);
  endfunction

  // Advances the decoder state by one item; returns 1 when the item yields a result.
  function automatic bit decode_item(input logic [1:0] op, input logic [7:0] b,
                                     output result_t r);
    int nib;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      nib = int'(b) - 'h30;
    end else if (b >= 8'h61 && b <= 8'h66) begin
      nib = int'(b) - 'h57;
    end else if (b >= 8'h41 && b <= 8'h46) begin
      nib = int'(b) - 'h37;
    end else begin
      nib = -1;
    end
    if (op == hcbd_pkg::OP_RESTART) begin
      start_body();
      return 1'b0;
    end
    if (op == OP_UNUSED || dec_phase == hcbd_pkg::PH_DONE ||
        dec_phase == hcbd_pkg::PH_ERROR) return 1'b0;
    if (op == hcbd_pkg::OP_END || b == 8'h00) begin
      r = fail_with(hcbd_pkg::ERR_EARLY_END);
      return 1'b1;
    end
    case (dec_phase)
      hcbd_pkg::PH_SIZE: begin
        if (b == hcbd_pkg::ASCII_CR || b == hcbd_pkg::ASCII_SEMI) begin
          if (!digit_seen) begin
            r = fail_with(hcbd_pkg::ERR_MISSING_SIZE);
            return 1'b1;
          end
          dec_phase = (b == hcbd_pkg::ASCII_CR) ? hcbd_pkg::PH_SIZE_LF : hcbd_pkg::PH_EXT;
          return 1'b0;
        end
        if (nib < 0) begin
          r = fail_with(hcbd_pkg::ERR_BAD_HEX);
          return 1'b1;
        end
        // The size register has no room left for another digit.
        if (chunk_left[SZ-1 -: 4] != 4'd0) begin
          r = fail_with(hcbd_pkg::ERR_OVERFLOW);
          return 1'b1;
        end
        chunk_left = {chunk_left[SZ-5:0], 4'(nib)};
        digit_seen = 1'b1;
        return 1'b0;
      end
      hcbd_pkg::PH_EXT: begin
        if (b == hcbd_pkg::ASCII_CR) dec_phase = hcbd_pkg::PH_SIZE_LF;
        return 1'b0;
      end
      hcbd_pkg::PH_SIZE_LF: begin
        if (b != hcbd_pkg::ASCII_LF) begin
          r = fail_with(hcbd_pkg::ERR_BAD_SIZE_CRLF);
          return 1'b1;
        end
        if (chunk_left == '0) begin
          dec_phase = hcbd_pkg::PH_DONE;
          r = mk_result(hcbd_pkg::KIND_DONE, 8'h00, NO_CODE);
          return 1'b1;
        end
        dec_phase = hcbd_pkg::PH_DATA;
        return 1'b0;
      end
      hcbd_pkg::PH_DATA: begin
        if (room_left <= 1) begin
          r = fail_with(hcbd_pkg::ERR_FULL);
          return 1'b1;
        end
        room_left--;
        chunk_left--;
        if (chunk_left == '0) dec_phase = hcbd_pkg::PH_DATA_CR;
        r = mk_result(hcbd_pkg::KIND_DATA, b, NO_CODE);
        return 1'b1;
      end
      hcbd_pkg::PH_DATA_CR: begin
        if (b != hcbd_pkg::ASCII_CR) begin
          r = fail_with(hcbd_pkg::ERR_BAD_DATA_CRLF);
          return 1'b1;
        end
        dec_phase = hcbd_pkg::PH_DATA_LF;
        return 1'b0;
      end
      hcbd_pkg::PH_DATA_LF: begin
        if (b != hcbd_pkg::ASCII_LF) begin
          r = fail_with(hcbd_pkg::ERR_BAD_DATA_CRLF);
          return 1'b1;
        end
        dec_phase = hcbd_pkg::PH_SIZE;
        chunk_left = '0;
        digit_seen = 1'b0;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Sends one item; a fixed expectation, when given, replaces the predicted one.
  task automatic feed(input logic [1:0] op, input logic [7:0] b, input bit fixed,
                      input bit fixed_has, input result_t fixed_res);
    int gap;
    bit rdy;
    bit has;
    result_t r;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= b;
    s_user <= op;
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready_o;
      @(posedge clk_i);
    end while (!rdy);
    has = decode_item(op, b, r);
    if (fixed) begin
      has = fixed_has;
      r = fixed_res;
    end
    if (has) decoder_out_q.push_back(r);
    fed_items++;
  endtask

  task automatic drain_results();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (decoder_out_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [hcbd_pkg::CAP_W-1:0] value);
    bit rdy;
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do begin
      @(negedge clk_i);
      rdy = cfg_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    cfg_valid <= 1'b0;
    capacity_reg = value;
  endtask

  // Results are sampled mid-cycle; the transfer itself completes at the next rising edge.
  always @(negedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      if (decoder_out_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d byte %02h code %0d",
                   m_axis_tuser_o, m_axis_tdata_o[7:0], m_axis_tdata_o[10:8]);
      end else begin
        want = decoder_out_q.pop_front();
        if (want.kind != m_axis_tuser_o || want.data != m_axis_tdata_o[7:0] ||
            want.code != m_axis_tdata_o[10:8]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: kind %0d/%0d byte %02h/%02h code %0d/%0d (expected/actual)",
                     want.kind, m_axis_tuser_o, want.data, m_axis_tdata_o[7:0],
                     want.code, m_axis_tdata_o[10:8]);
        end
      end
    end
  end

  function automatic void row(logic [1:0] op, logic [7:0] data, int reps = 1);
    plan_q.push_back('{op, data, reps, 1'b0, 1'b0, result_t'(0)});
  endfunction

  function automatic void row_fixed(logic [1:0] op, logic [7:0] data, bit has, result_t res);
    plan_q.push_back('{op, data, 1, 1'b1, has, res});
  endfunction

  function automatic logic [7:0] hex_char(int unsigned nib);
    if (nib < 10) return 8'(8'h30 + nib);
    return 8'(($urandom_range(1) ? 8'h41 : 8'h61) + nib - 10);
  endfunction

  function automatic void push_byte(logic [7:0] b);
    body_q.push_back({hcbd_pkg::OP_BYTE, b});
  endfunction

  // Size line: hex digits with optional leading zeros, an optional extension, CR LF.
  function automatic void push_size_line(int unsigned size);
    int n;
    int unsigned rest;
    logic [7:0] b;
    n = 0;
    rest = size;
    do begin
      n++;
      rest = rest >> 4;
    end while (rest != 0);
    repeat ($urandom_range(2)) push_byte(8'h30);
    for (int k = n - 1; k >= 0; k--) push_byte(hex_char((size >> (4 * k)) & 15));
    if ($urandom_range(3) == 0) begin
      push_byte(hcbd_pkg::ASCII_SEMI);
      repeat ($urandom_range(3)) begin
        b = 8'($urandom_range(1, 255));
        push_byte(b == hcbd_pkg::ASCII_CR ? 8'hFF : b);
      end
    end
    push_byte(hcbd_pkg::ASCII_CR);
    push_byte(hcbd_pkg::ASCII_LF);
  endfunction

  function automatic void build_body();
    int unsigned mode;
    int unsigned size;
    int unsigned idx;
    body_q.delete();
    body_q.push_back({hcbd_pkg::OP_RESTART, 8'($urandom_range(255))});
    mode = $urandom_range(99);
    if (mode < 8) begin
      // A size with a nonzero first digit and at least nine digits overflows.
      push_byte(hex_char($urandom_range(1, 15)));
      repeat ($urandom_range(8, 10)) push_byte(hex_char($urandom_range(15)));
      push_byte(hcbd_pkg::ASCII_CR);
      push_byte(hcbd_pkg::ASCII_LF);
      return;
    end
    if (mode < 14) begin
      repeat ($urandom_range(4, 12))
        body_q.push_back({2'($urandom_range(3)), 8'($urandom_range(255))});
      return;
    end
    repeat ($urandom_range(3)) begin
      size = ($urandom_range(9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 6);
      push_size_line(size);
      repeat (size) push_byte(8'($urandom_range(1, 255)));
      push_byte(hcbd_pkg::ASCII_CR);
      push_byte(hcbd_pkg::ASCII_LF);
    end
    push_size_line(0);
    if (mode < 34) begin
      idx = $urandom_range(1, body_q.size() - 1);
      if ($urandom_range(7) == 0) body_q[idx] = {hcbd_pkg::OP_END, 8'($urandom_range(255))};
      else body_q[idx][7:0] = 8'($urandom_range(255));
    end
  endfunction

  initial begin
    int start_count;
    rst_ni = 1'b0;
    s_valid = 1'b0;
    s_data = 8'h00;
    s_user = hcbd_pkg::OP_BYTE;
    cfg_valid = 1'b0;
    cfg_data = '0;
    hold_requests = 0;
    fed_items = 0;
    mismatches = 0;
    send_idle_pct = 9;
    recv_idle_pct = 63;
    capacity_reg = hcbd_pkg::CAP_W'(hcbd_pkg::CAP_RESET);
    start_body();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    row_fixed(hcbd_pkg::OP_BYTE, hcbd_pkg::ASCII_SEMI, 1'b1,
              mk_result(hcbd_pkg::KIND_ERROR, 8'h00, hcbd_pkg::ERR_MISSING_SIZE));
    row_fixed(hcbd_pkg::OP_END, 8'h00, 1'b0, '0);
    row_fixed(hcbd_pkg::OP_RESTART, 8'h00, 1'b0, '0);
    row_fixed(OP_UNUSED, 8'hFF, 1'b0, '0);
    row_fixed(hcbd_pkg::OP_BYTE, 8'h67, 1'b1,
              mk_result(hcbd_pkg::KIND_ERROR, 8'h00, hcbd_pkg::ERR_BAD_HEX));
    row(hcbd_pkg::OP_RESTART, 8'hFF);
    // Two data bytes behind an extension, then a broken data trailer.
    row(hcbd_pkg::OP_BYTE, 8'h32);
    row(hcbd_pkg::OP_BYTE, hcbd_pkg::ASCII_SEMI);
    row(hcbd_pkg::OP_BYTE, 8'hFF);
    row(hcbd_pkg::OP_BYTE, hcbd_pkg::ASCII_CR);
    row(hcbd_pkg::OP_BYTE, hcbd_pkg::ASCII_LF);
    row(hcbd_pkg::OP_BYTE, 8'hFF);
    row(hcbd_pkg::OP_BYTE, 8'h80);
    row_fixed(hcbd_pkg::OP_BYTE, hcbd_pkg::ASCII_LF, 1'b1,
              mk_result(hcbd_pkg::KIND_ERROR, 8'h00, hcbd_pkg::ERR_BAD_DATA_CRLF));
    row(hcbd_pkg::OP_RESTART, 8'h00);
    row(hcbd_pkg::OP_BYTE, 8'h42);
    row(hcbd_pkg::OP_BYTE, hcbd_pkg::ASCII_CR);
    row_fixed(hcbd_pkg::OP_BYTE, 8'h58, 1'b1,
              mk_result(hcbd_pkg::KIND_ERROR, 8'h00, hcbd_pkg::ERR_BAD_SIZE_CRLF));
    row(hcbd_pkg::OP_RESTART, 8'h00);
    row(hcbd_pkg::OP_BYTE, 8'h30);
    row(hcbd_pkg::OP_BYTE, hcbd_pkg::ASCII_CR);
    row_fixed(hcbd_pkg::OP_BYTE, hcbd_pkg::ASCII_LF, 1'b1,
              mk_result(hcbd_pkg::KIND_DONE, 8'h00, NO_CODE));
    row_fixed(hcbd_pkg::OP_BYTE, 8'h31, 1'b0, '0);
    row(hcbd_pkg::OP_RESTART, 8'h00);
    row(hcbd_pkg::OP_BYTE, 8'h31);
    row_fixed(hcbd_pkg::OP_BYTE, 8'h00, 1'b1,
              mk_result(hcbd_pkg::KIND_ERROR, 8'h00, hcbd_pkg::ERR_EARLY_END));
    row(hcbd_pkg::OP_RESTART, 8'h00);
    row(hcbd_pkg::OP_BYTE, 8'h31);
    row(hcbd_pkg::OP_BYTE, 8'h30, 7);
    row_fixed(hcbd_pkg::OP_BYTE, 8'h46, 1'b1,
              mk_result(hcbd_pkg::KIND_ERROR, 8'h00, hcbd_pkg::ERR_OVERFLOW));

    foreach (plan_q[i])
      repeat (plan_q[i].reps)
        feed(plan_q[i].op, plan_q[i].data, plan_q[i].fixed, plan_q[i].has, plan_q[i].res);

    for (int seg = 0; seg < 5; seg++) begin
      write_capacity(hcbd_pkg::CAP_W'(seg_cap[seg]));
      send_idle_pct = (seg < 2) ? 9 : (seg < 4) ? 63 : 0;
      recv_idle_pct = (seg < 2) ? 63 : (seg < 4) ? 9 : 0;
      // The receiver stops for a long stretch while bodies keep coming.
      if (seg == 2) hold_requests++;
      start_count = fed_items;
      while (fed_items - start_count < SEG_ITEMS) begin
        build_body();
        foreach (body_q[i]) feed(body_q[i][9:8], body_q[i][7:0], 1'b0, 1'b0, '0);
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
